### design/assert_macros.svh
// Assertion helpers shared by the scanner RTL.
// ASSERT_ON checks that a property holds on every clock edge outside reset.
// ASSERT_NEVER checks that a condition is never true outside reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ON(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

`define ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_ON(lbl, clk, rst, prop)

`define ASSERT_NEVER(lbl, clk, rst, cond)

`endif

`endif

### design/aet_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package aet_pkg;

  // Field widths
  localparam int CH_W     = 8;
  localparam int KIND_W   = 3;
  localparam int VALUE_W  = 31;
  localparam int LINE_W   = 24;
  localparam int LINE_BITS = 24;

  // Request queue between scanner front and token back end
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam logic [VALUE_W-1:0] VALUE_MAX = '1;

  // Source characters
  localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CH_W-1:0] CH_NL    = 8'h0A;
  localparam logic [CH_W-1:0] CH_FF    = 8'h0C;
  localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CH_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE  = 8'h39;

  typedef enum logic [KIND_W-1:0] {
    TK_END   = 3'd0,
    TK_PLUS  = 3'd1,
    TK_MINUS = 3'd2,
    TK_STAR  = 3'd3,
    TK_SLASH = 3'd4,
    TK_INT   = 3'd5,
    TK_ERR   = 3'd6
  } tok_kind_t;

  // One request from the front: an optional integer token, then an
  // optional operator/end/error token, both on the same line.
  typedef struct packed {
    logic              has_int;
    logic [VALUE_W-1:0] int_val;
    logic              has_op;
    tok_kind_t         op_kind;
    logic [CH_W-1:0]   bad_char;
    logic [LINE_W-1:0] line;
  } job_t;

endpackage

`default_nettype wire

### design/aet_front.sv
`timescale 1ns / 1ps
`default_nettype none

module aet_front (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     ch_valid,
  output logic                          ch_stall,
  input  wire logic [aet_pkg::CH_W-1:0] ch,
  output logic                          push,
  output aet_pkg::job_t                 push_data,
  input  wire logic                     full
);
  import aet_pkg::*;

  logic                 in_number;
  logic [VALUE_W-1:0]   number_accum;
  logic [LINE_BITS-1:0] line_count;

  logic                     is_digit;
  logic [3:0]               digit;
  logic [VALUE_W+3:0]       accum_mul;
  logic [VALUE_W-1:0]       accum_next;
  logic [LINE_BITS-1:0]     line_next;
  logic [LINE_BITS+LINE_W-1:0] line_ext;
  logic                     accept;

  // Stall only when the request queue has no room
  assign ch_stall = full;
  assign accept   = ch_valid && !ch_stall;

  // Classify the byte and decode a digit
  always_comb begin
    is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    digit    = 4'(ch - CH_ZERO);
  end

  // Accumulate value*10+digit, saturating
  always_comb begin
    accum_mul = {1'b0, number_accum, 3'b000} + {3'b000, number_accum, 1'b0}
              + {{VALUE_W{1'b0}}, digit};
    if (!in_number) begin
      accum_next = {{(VALUE_W-4){1'b0}}, digit};
    end else if (accum_mul[VALUE_W+3:VALUE_W] != '0) begin
      accum_next = VALUE_MAX;
    end else begin
      accum_next = accum_mul[VALUE_W-1:0];
    end
  end

  // Count a newline before any token of this byte
  always_comb begin
    line_next = line_count;
    if (ch == CH_NL && line_count != '1) begin
      line_next = line_count + 1'b1;
    end
    line_ext = {{LINE_W{1'b0}}, line_next};
  end

  // Build the request for a non-digit byte
  always_comb begin
    push_data.has_int  = in_number;
    push_data.int_val  = number_accum;
    push_data.has_op   = 1'b1;
    push_data.op_kind  = TK_ERR;
    push_data.bad_char = '0;
    push_data.line     = line_ext[LINE_W-1:0];
    case (ch)
      CH_NUL:   push_data.op_kind = TK_END;
      CH_PLUS:  push_data.op_kind = TK_PLUS;
      CH_MINUS: push_data.op_kind = TK_MINUS;
      CH_STAR:  push_data.op_kind = TK_STAR;
      CH_SLASH: push_data.op_kind = TK_SLASH;
      CH_SPACE, CH_TAB, CH_NL, CH_CR, CH_FF: push_data.has_op = 1'b0;
      default: begin
        push_data.op_kind  = TK_ERR;
        push_data.bad_char = ch;
      end
    endcase
    push = accept && !is_digit && (in_number || push_data.has_op);
  end

  // Advance scanner state on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      in_number    <= 1'b0;
      number_accum <= '0;
      line_count   <= LINE_BITS'(1);
    end else if (accept) begin
      if (is_digit) begin
        in_number    <= 1'b1;
        number_accum <= accum_next;
      end else begin
        in_number    <= 1'b0;
        number_accum <= '0;
        line_count   <= (ch == CH_NUL) ? LINE_BITS'(1) : line_next;
      end
    end
  end

endmodule

`default_nettype wire

### design/aet_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module aet_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire aet_pkg::job_t push_data,
  output logic               full,
  input  wire logic          pop,
  output aet_pkg::job_t      pop_data,
  output logic               empty
);
  import aet_pkg::*;

  job_t             slots [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(FIFO_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  // Store requests in arrival order
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

  `ASSERT_NEVER(a_no_push_full, clk, rst, push && full)
  `ASSERT_NEVER(a_no_pop_empty, clk, rst, pop && empty)

endmodule

`default_nettype wire

### design/aet_back.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module aet_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire aet_pkg::job_t               head,
  input  wire logic                        empty,
  output logic                             pop,
  output logic                             tok_valid,
  input  wire logic                        tok_stall,
  output logic [aet_pkg::KIND_W-1:0]       token_kind,
  output logic [aet_pkg::VALUE_W-1:0]      int_value,
  output logic [aet_pkg::CH_W-1:0]         bad_char,
  output logic [aet_pkg::LINE_W-1:0]       line_number,
  output logic                             last
);
  import aet_pkg::*;

  logic               phase;
  logic               phase_next;
  logic               load;
  logic               emit;
  tok_kind_t          kind_sel;
  logic [VALUE_W-1:0] val_sel;
  logic [CH_W-1:0]    bad_sel;
  logic               last_sel;

  // The output register may take a new token when empty or being drained
  assign load = !tok_valid || !tok_stall;

  // Pick the next token: integer first, then the operator token
  always_comb begin
    pop        = 1'b0;
    emit       = 1'b0;
    phase_next = phase;
    kind_sel   = head.op_kind;
    val_sel    = '0;
    bad_sel    = head.bad_char;
    last_sel   = 1'b1;
    if (load && !empty) begin
      emit = 1'b1;
      if (!phase && head.has_int) begin
        kind_sel = TK_INT;
        val_sel  = head.int_val;
        bad_sel  = '0;
        last_sel = !head.has_op;
        if (head.has_op) begin
          phase_next = 1'b1;
        end else begin
          pop = 1'b1;
        end
      end else begin
        pop        = 1'b1;
        phase_next = 1'b0;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid <= 1'b0;
      phase     <= 1'b0;
    end else begin
      phase <= phase_next;
      if (load) begin
        tok_valid <= emit;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (emit) begin
      token_kind  <= kind_sel;
      int_value   <= val_sel;
      bad_char    <= bad_sel;
      line_number <= head.line;
      last        <= last_sel;
    end
  end

  `ASSERT_ON(a_second_has_job, clk, rst, phase |-> !empty)
  `ASSERT_ON(a_int_only_literal, clk, rst,
             (tok_valid && token_kind != TK_INT) |-> (int_value == '0))

endmodule

`default_nettype wire

### design/arith_expr_tokenizer_core.sv
// Channel  | Signals                         | Request
// ---------+---------------------------------+---------------------------------
// input    | ch_valid, ch_stall, ch          | one source byte
// output   | tok_valid, tok_stall, token_*   | one token (kind, value, char,
//          | int_value, bad_char, line_number| line, last)
//
// One byte is taken per cycle while the four-entry request queue has room.
// A number that ends on an operator, NUL or bad byte gives two tokens; the
// single output register then sends them in turn, integer first.
// A request passes through the queue, then the output register.
// Synchronous reset clears scanner state, queue and output valid; the line
// count restarts at 1. Output stall backs up into the queue and then ch_stall.
`timescale 1ns / 1ps
`default_nettype none

module arith_expr_tokenizer_core (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        ch_valid,
  output logic                             ch_stall,
  input  wire logic [aet_pkg::CH_W-1:0]    ch,
  output logic                             tok_valid,
  input  wire logic                        tok_stall,
  output logic [aet_pkg::KIND_W-1:0]       token_kind,
  output logic [aet_pkg::VALUE_W-1:0]      int_value,
  output logic [aet_pkg::CH_W-1:0]         bad_char,
  output logic [aet_pkg::LINE_W-1:0]       line_number,
  output logic                             last
);
  import aet_pkg::*;

  logic push;
  job_t push_data;
  logic full;
  logic pop;
  job_t head;
  logic empty;

  aet_front u_front (
    .clk       (clk),
    .rst       (rst),
    .ch_valid  (ch_valid),
    .ch_stall  (ch_stall),
    .ch        (ch),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  aet_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (head),
    .empty     (empty)
  );

  aet_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .empty       (empty),
    .pop         (pop),
    .tok_valid   (tok_valid),
    .tok_stall   (tok_stall),
    .token_kind  (token_kind),
    .int_value   (int_value),
    .bad_char    (bad_char),
    .line_number (line_number),
    .last        (last)
  );

endmodule

`default_nettype wire

### sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import aet_pkg::*;

  localparam int HOLD_CYCLES  = 80;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 1750;

  typedef struct {
    tok_kind_t          kind;
    logic [VALUE_W-1:0] value;
    logic [CH_W-1:0]    bad;
    logic [LINE_W-1:0]  line;
    logic               last;
  } token_t;

  // One source byte, optionally with its tokens typed in by hand
  typedef struct {
    logic [CH_W-1:0] c;
    bit              typed;
    int              n;
    token_t          t0;
    token_t          t1;
  } script_row_t;

  logic                clk;
  logic                rst;
  logic                ch_valid;
  logic                ch_stall;
  logic [CH_W-1:0]     ch;
  logic                tok_valid;
  logic                tok_stall;
  logic [KIND_W-1:0]   token_kind;
  logic [VALUE_W-1:0]  int_value;
  logic [CH_W-1:0]     bad_char;
  logic [LINE_W-1:0]   line_number;
  logic                last;

  arith_expr_tokenizer_core dut (
    .clk         (clk),
    .rst         (rst),
    .ch_valid    (ch_valid),
    .ch_stall    (ch_stall),
    .ch          (ch),
    .tok_valid   (tok_valid),
    .tok_stall   (tok_stall),
    .token_kind  (token_kind),
    .int_value   (int_value),
    .bad_char    (bad_char),
    .line_number (line_number),
    .last        (last)
  );

  // Scanner shadow state
  logic                 scan_in_num;
  logic [VALUE_W-1:0]   scan_accum;
  logic [LINE_BITS-1:0] scan_line;
  token_t               scan_out [2];

  token_t      pending_tokens [$];
  script_row_t directed [$];
  script_row_t cur_row;
  token_t      nil;

  int  n_fail;
  int  items_sent;
  int  burst_left;
  bit  gaps_on;
  bit  hold_req;
  int  hold_left;
  int  mode_left;
  int  stall_mode;
  int  stall_phase;
  int  cycles;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic token_t mk_tok(tok_kind_t k, logic [VALUE_W-1:0] v,
                                    logic [CH_W-1:0] b, logic [LINE_W-1:0] l, logic lst);
    token_t t;
    t.kind  = k;
    t.value = v;
    t.bad   = b;
    t.line  = l;
    t.last  = lst;
    return t;
  endfunction

  function automatic script_row_t row(logic [CH_W-1:0] c, bit typed, int n,
                                      token_t t0, token_t t1);
    script_row_t r;
    r.c     = c;
    r.typed = typed;
    r.n     = n;
    r.t0    = t0;
    r.t1    = t1;
    return r;
  endfunction

  // Advance the shadow scanner by one byte; tokens land in scan_out
  function automatic int scan_byte(logic [CH_W-1:0] c);
    logic [63:0] grown;
    int n;
    n = 0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      if (scan_in_num) begin
        grown = 64'(scan_accum) * 64'd10 + 64'(c - CH_ZERO);
        scan_accum = (grown > 64'(VALUE_MAX)) ? VALUE_MAX : grown[VALUE_W-1:0];
      end else begin
        scan_in_num = 1'b1;
        scan_accum  = VALUE_W'(c - CH_ZERO);
      end
      return 0;
    end
    // count the newline before a pending number goes out
    if (c == CH_NL && scan_line != '1) scan_line = scan_line + 1'b1;
    if (scan_in_num) begin
      scan_out[n] = mk_tok(TK_INT, scan_accum, '0, LINE_W'(scan_line), 1'b0);
      n++;
      scan_in_num = 1'b0;
      scan_accum  = '0;
    end
    case (c)
      CH_NUL: begin
        scan_out[n] = mk_tok(TK_END, '0, '0, LINE_W'(scan_line), 1'b0);
        n++;
        scan_line = 1;
      end
      CH_SPACE, CH_TAB, CH_NL, CH_CR, CH_FF: ;
      CH_PLUS: begin
        scan_out[n] = mk_tok(TK_PLUS, '0, '0, LINE_W'(scan_line), 1'b0);
        n++;
      end
      CH_MINUS: begin
        scan_out[n] = mk_tok(TK_MINUS, '0, '0, LINE_W'(scan_line), 1'b0);
        n++;
      end
      CH_STAR: begin
        scan_out[n] = mk_tok(TK_STAR, '0, '0, LINE_W'(scan_line), 1'b0);
        n++;
      end
      CH_SLASH: begin
        scan_out[n] = mk_tok(TK_SLASH, '0, '0, LINE_W'(scan_line), 1'b0);
        n++;
      end
      default: begin
        scan_out[n] = mk_tok(TK_ERR, '0, c, LINE_W'(scan_line), 1'b0);
        n++;
      end
    endcase
    if (n > 0) scan_out[n-1].last = 1'b1;
    return n;
  endfunction

  function automatic void check_field(string name, longint unsigned want,
                                      longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_fail++;
    end
  endfunction

  // Predict on each accepted request, then check each accepted token
  always @(posedge clk) begin
    token_t want;
    int n;
    if (!rst) begin
      if (ch_valid && !ch_stall) begin
        n = scan_byte(ch);
        if (cur_row.typed) begin
          if (cur_row.n > 0) pending_tokens.push_back(cur_row.t0);
          if (cur_row.n > 1) pending_tokens.push_back(cur_row.t1);
        end else begin
          for (int i = 0; i < n; i++) pending_tokens.push_back(scan_out[i]);
        end
      end
      if (tok_valid && !tok_stall) begin
        if (pending_tokens.size() == 0) begin
          $error("token with none expected: kind %0d value %0d", token_kind, int_value);
          n_fail++;
        end else begin
          want = pending_tokens.pop_front();
          check_field("token_kind", want.kind, token_kind);
          check_field("int_value", want.value, int_value);
          check_field("bad_char", want.bad, bad_char);
          check_field("line_number", want.line, line_number);
          check_field("last", want.last, last);
        end
      end
    end
  end

  // Receiver stall: long hold-off on request, else a pattern that changes mode
  always @(negedge clk) begin
    if (rst) begin
      tok_stall <= 1'b0;
    end else if (hold_left > 0) begin
      tok_stall <= 1'b1;
      hold_left--;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES - 1;
      tok_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(20, 200);
      end
      mode_left--;
      stall_phase++;
      case (stall_mode)
        0: tok_stall <= 1'b0;
        1: tok_stall <= ($urandom_range(0, 3) == 0);
        2: tok_stall <= ($urandom_range(0, 3) != 0);
        default: tok_stall <= (stall_phase % 4) != 0;
      endcase
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Offer one request, idling first when a burst runs out and gaps are on; return once accepted
  task automatic feed(script_row_t r);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gaps_on) begin
        @(negedge clk);
        ch_valid <= 1'b0;
        repeat ($urandom_range(0, 5)) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    cur_row = r;
    ch_valid <= 1'b1;
    ch <= r.c;
    do @(posedge clk); while (ch_stall);
    items_sent++;
  endtask

  task automatic feed_byte(logic [CH_W-1:0] c);
    feed(row(c, 1'b0, 0, nil, nil));
  endtask

  function automatic logic [CH_W-1:0] pick_space();
    case ($urandom_range(0, 4))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_NL;
      3: return CH_CR;
      default: return CH_FF;
    endcase
  endfunction

  // Number, optional whitespace, then an operator, end, newline or stray byte
  task automatic feed_expr_piece();
    int len;
    int pick;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 13) : $urandom_range(1, 4);
    repeat (len) feed_byte(CH_ZERO + CH_W'($urandom_range(0, 9)));
    repeat ($urandom_range(0, 2)) feed_byte(pick_space());
    pick = $urandom_range(0, 99);
    if (pick < 80) begin
      case ($urandom_range(0, 3))
        0: feed_byte(CH_PLUS);
        1: feed_byte(CH_MINUS);
        2: feed_byte(CH_STAR);
        default: feed_byte(CH_SLASH);
      endcase
    end else if (pick < 88) begin
      feed_byte(CH_NUL);
    end else if (pick < 94) begin
      feed_byte(CH_NL);
    end else begin
      feed_byte(CH_W'($urandom_range(128, 255)));
    end
  endtask

  // Drop valid and wait for every expected token
  task automatic drain();
    @(negedge clk);
    ch_valid <= 1'b0;
    do @(posedge clk); while (pending_tokens.size() != 0);
  endtask

  initial begin
    rst         = 1'b1;
    ch_valid    = 1'b0;
    ch          = '0;
    tok_stall   = 1'b0;
    scan_in_num = 1'b0;
    scan_accum  = '0;
    scan_line   = 1;
    n_fail      = 0;
    items_sent  = 0;
    burst_left  = 0;
    gaps_on     = 1'b1;
    hold_req    = 1'b0;
    hold_left   = 0;
    mode_left   = 0;
    stall_mode  = 0;
    stall_phase = 0;
    cycles      = 0;
    nil = mk_tok(TK_END, '0, '0, '0, 1'b0);
    cur_row = row(CH_NUL, 1'b0, 0, nil, nil);

    // operators, a bad byte, whitespace, newline ending a number, end of input,
    // then an overflowing literal
    directed.push_back(row(CH_PLUS, 1, 1, mk_tok(TK_PLUS, '0, '0, 1, 1), nil));
    directed.push_back(row(CH_MINUS, 1, 1, mk_tok(TK_MINUS, '0, '0, 1, 1), nil));
    directed.push_back(row(CH_STAR, 1, 1, mk_tok(TK_STAR, '0, '0, 1, 1), nil));
    directed.push_back(row(CH_SLASH, 1, 1, mk_tok(TK_SLASH, '0, '0, 1, 1), nil));
    directed.push_back(row(8'hFF, 1, 1, mk_tok(TK_ERR, '0, 8'hFF, 1, 1), nil));
    directed.push_back(row(CH_SPACE, 1, 0, nil, nil));
    directed.push_back(row(CH_TAB, 1, 0, nil, nil));
    directed.push_back(row(CH_CR, 1, 0, nil, nil));
    directed.push_back(row(CH_FF, 1, 0, nil, nil));
    directed.push_back(row(CH_ZERO + 8'd7, 0, 0, nil, nil));
    directed.push_back(row(CH_NL, 0, 0, nil, nil));
    directed.push_back(row(CH_ZERO + 8'd5, 0, 0, nil, nil));
    directed.push_back(row(CH_NUL, 0, 0, nil, nil));
    repeat (10) directed.push_back(row(CH_NINE, 0, 0, nil, nil));
    directed.push_back(row(CH_SLASH, 1, 2, mk_tok(TK_INT, VALUE_MAX, '0, 1, 0),
                           mk_tok(TK_SLASH, '0, '0, 1, 1)));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed[i]) feed(directed[i]);

    // hold the receiver off while requests keep coming, so the input backs up
    drain();
    hold_req   = 1'b1;
    gaps_on    = 1'b0;
    burst_left = 1000;
    while (items_sent < 24 + 60) feed_expr_piece();
    drain();
    burst_left = 0;
    gaps_on    = 1'b1;

    // random mix: mostly well-formed expressions, some noise bytes
    while (items_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 199) == 0) gaps_on = ($urandom_range(0, 2) != 0);
      if ($urandom_range(0, 99) < 78) feed_expr_piece();
      else feed_byte(CH_W'($urandom_range(0, 255)));
    end

    drain();
    repeat (8) @(posedge clk);
    if (n_fail == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### files.f
+incdir+design
design/aet_pkg.sv
design/aet_front.sv
design/aet_fifo.sv
design/aet_back.sv
design/arith_expr_tokenizer_core.sv
sim/tb_top.sv
